// ===== hdl/skl_pkg.sv =====
// Package for the streaming k-th largest block.
// Holds the default sizes and the link type shared by the cell and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package skl_pkg;

    localparam int CAPACITY_DEF    = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int RANK_BITS       = 7;

    typedef struct packed {
        logic valid;
        logic ins;
    } t_link;

endpackage

`default_nettype wire

// ===== hdl/skl_cell.sv =====
// One cell of the sorted chain: holds one sample and its valid flag.
// Depends on skl_pkg for the link type between neighbouring cells.
`timescale 1ns / 1ps
`default_nettype none

module skl_cell #(
    parameter int SAMPLE_BITS = 16,
    parameter int IDX_BITS    = 6,
    parameter int IDX         = 0
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_en,
    input  wire signed [SAMPLE_BITS-1:0]  i_sample,
    input  skl_pkg::t_link                i_prev_link,
    input  wire signed [SAMPLE_BITS-1:0]  i_prev_value,
    input  wire                           i_next_valid,
    input  wire        [IDX_BITS-1:0]     i_kk_m1,
    output skl_pkg::t_link                o_link,
    output logic signed [SAMPLE_BITS-1:0] o_value,
    output logic                          o_tap,
    output logic                          o_full
);
    import skl_pkg::*;

    logic                          r_valid;
    logic signed [SAMPLE_BITS-1:0] r_value;
    logic                          w_ins;
    logic                          w_at_k;
    logic                          w_below_k;

    // The new sample goes at or before this cell when the cell is empty or smaller.
    assign w_ins     = !r_valid || (r_value < i_sample);
    assign w_at_k    = (IDX_BITS'(IDX) == i_kk_m1);
    assign w_below_k = (IDX_BITS'(IDX) < i_kk_m1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en && w_ins) begin
            r_valid <= r_valid | i_prev_link.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && w_ins) begin
            r_value <= i_prev_link.ins ? i_prev_value : i_sample;
        end
    end

    assign o_link.valid = r_valid;
    assign o_link.ins   = w_ins;
    assign o_value      = r_value;
    assign o_tap        = r_valid && (w_at_k || (w_below_k && !i_next_valid));
    assign o_full       = r_valid && w_at_k;

endmodule

`default_nettype wire

// ===== hdl/stream_kth_largest_core.sv =====
// Top level of the streaming k-th largest block: a sorted chain of cells
// and the registered result stage. Depends on skl_pkg and skl_cell.
//
// Usage: one signed sample enters per transaction on the input channel
// (i_valid, o_stall, i_sample). Every input transaction yields exactly one
// output transaction (o_valid, i_stall, o_kth_value, o_full_res) carrying the
// k-th largest sample held so far, or the smallest held one while fewer than
// k are held; o_full_res is high once at least k samples are held.
// The rank k is written through i_cfg_we and i_cfg_wdata while the block is
// idle; 0 counts as 1 and values above the capacity count as the capacity.
// Throughput is one transaction per cycle while the output is not stalled:
// every cell compares against the new sample at once and shifts in the same
// cycle, and the result is picked from the updated chain and registered in the
// result stage. When the receiver stalls a valid result, the output holds
// and the chain stops, so o_stall rises in the same cycle.
// Synchronous reset empties the chain, clears both pipeline stages and sets
// k to 1; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module stream_kth_largest_core #(
    parameter int CAPACITY    = skl_pkg::CAPACITY_DEF,
    parameter int SAMPLE_BITS = skl_pkg::SAMPLE_BITS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_valid,
    output logic                            o_stall,
    input  wire signed [SAMPLE_BITS-1:0]    i_sample,
    output logic                            o_valid,
    input  wire                             i_stall,
    output logic signed [SAMPLE_BITS-1:0]   o_kth_value,
    output logic                            o_full_res,
    input  wire                             i_cfg_we,
    input  wire [skl_pkg::RANK_BITS-1:0]    i_cfg_wdata
);
    import skl_pkg::*;

    localparam int IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [IDX_BITS-1:0]           r_kk_m1;
    logic [IDX_BITS-1:0]           n_kk_m1;
    logic                          r_p1;
    logic                          r_o_valid;
    logic signed [SAMPLE_BITS-1:0] r_kth;
    logic                          r_full;

    logic                          w_adv;
    logic                          w_acc;
    t_link                         w_link [CAPACITY];
    logic signed [SAMPLE_BITS-1:0] w_value [CAPACITY];
    logic [CAPACITY-1:0]           w_tap;
    logic [CAPACITY-1:0]           w_full;
    logic [CAPACITY-1:0]           w_vld;
    logic [CAPACITY-1:0]           w_bits [SAMPLE_BITS];
    logic [SAMPLE_BITS-1:0]        w_pick;

    assign w_adv   = !r_o_valid || !i_stall;
    assign w_acc   = i_valid && w_adv;
    assign o_stall = !w_adv;

    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_kk_m1 = '0;
        end else if (32'(i_cfg_wdata) > 32'(CAPACITY)) begin
            n_kk_m1 = IDX_BITS'(CAPACITY - 1);
        end else begin
            n_kk_m1 = IDX_BITS'(i_cfg_wdata - RANK_BITS'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kk_m1 <= '0;
        end else if (i_cfg_we) begin
            r_kk_m1 <= n_kk_m1;
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            t_link                         w_prev_link;
            logic signed [SAMPLE_BITS-1:0] w_prev_value;
            logic                          w_next_valid;

            if (g == 0) begin : g_first
                assign w_prev_link.valid = 1'b1;
                assign w_prev_link.ins   = 1'b0;
                assign w_prev_value      = i_sample;
            end else begin : g_inner
                assign w_prev_link  = w_link[g-1];
                assign w_prev_value = w_value[g-1];
            end

            if (g == CAPACITY - 1) begin : g_last
                assign w_next_valid = 1'b0;
            end else begin : g_more
                assign w_next_valid = w_link[g+1].valid;
            end

            skl_cell #(
                .SAMPLE_BITS (SAMPLE_BITS),
                .IDX_BITS    (IDX_BITS),
                .IDX         (g)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_en         (w_acc),
                .i_sample     (i_sample),
                .i_prev_link  (w_prev_link),
                .i_prev_value (w_prev_value),
                .i_next_valid (w_next_valid),
                .i_kk_m1      (r_kk_m1),
                .o_link       (w_link[g]),
                .o_value      (w_value[g]),
                .o_tap        (w_tap[g]),
                .o_full       (w_full[g])
            );

            assign w_vld[g] = w_link[g].valid;
        end
    endgenerate

    // At most one cell is tapped, so the result is an AND-OR over the chain.
    always_comb begin
        for (int b = 0; b < SAMPLE_BITS; b++) begin
            for (int c = 0; c < CAPACITY; c++) begin
                w_bits[b][c] = w_tap[c] & w_value[c][b];
            end
        end
    end

    generate
        for (g = 0; g < SAMPLE_BITS; g++) begin : g_pick
            assign w_pick[g] = |w_bits[g];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1      <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (w_adv) begin
            r_p1      <= i_valid;
            r_o_valid <= r_p1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_kth  <= w_pick;
            r_full <= |w_full;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_kth_value = r_kth;
    assign o_full_res  = r_full;

    a_prefix : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_vld >> 1) & ~w_vld) == '0)
        else $error("Valid cells do not form a prefix of the chain.");

    a_tap_one : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tap))
        else $error("More than one cell is tapped for the result.");

    a_tap_any : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vld != '0) |-> (w_tap != '0))
        else $error("Samples are held but no cell is tapped.");

    a_grow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !w_vld[CAPACITY-1]) |=>
        ($countones(w_vld) == $past($countones(w_vld)) + 1))
        else $error("Held count did not grow after a transaction into a partly empty chain.");

    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && i_stall) |=> (r_o_valid && $stable(r_kth) && $stable(r_full)
            && $stable(w_vld)))
        else $error("Result or chain changed while the output was stalled.");

endmodule

`default_nettype wire

// ===== bench/stream_kth_largest_checker.sv =====
// Checker for the streaming k-th largest block: watches the sample, result and rank
// channels, keeps its own sorted list of the largest samples and compares every result.
// Depends on skl_pkg.
`timescale 1ns / 1ps

module stream_kth_largest_checker #(
    parameter int CAPACITY    = skl_pkg::CAPACITY_DEF,
    parameter int SAMPLE_BITS = skl_pkg::SAMPLE_BITS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    input  wire                             i_in_stall,
    input  wire signed [SAMPLE_BITS-1:0]    i_sample,
    input  wire                             i_out_valid,
    input  wire                             i_out_stall,
    input  wire signed [SAMPLE_BITS-1:0]    i_kth_value,
    input  wire                             i_full_res,
    input  wire                             i_cfg_we,
    input  wire [skl_pkg::RANK_BITS-1:0]    i_cfg_wdata,
    output int                              o_fail_count,
    output int                              o_outstanding,
    output int                              o_checked
);

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] kth;
        logic                          full;
    } t_ranked;

    logic signed [SAMPLE_BITS-1:0] kept [CAPACITY];
    int                            kept_n = 0;
    logic [skl_pkg::RANK_BITS-1:0] rank_reg = 1;
    t_ranked                       ranked_q [$];
    int                            fail_total = 0;
    int                            checked_total = 0;
    int                            outstanding = 0;

    assign o_fail_count  = fail_total;
    assign o_outstanding = outstanding;
    assign o_checked     = checked_total;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_total++;
    endtask

    // Equal samples go after those already held; a sample no larger than the
    // smallest of a full list is dropped.
    function automatic void keep_sample(input logic signed [SAMPLE_BITS-1:0] s);
        int pos;
        int last;
        pos = 0;
        while (pos < kept_n && kept[pos] >= s) pos++;
        if (pos >= CAPACITY) return;
        last = (kept_n < CAPACITY) ? kept_n : CAPACITY - 1;
        for (int i = last; i > pos; i--) kept[i] = kept[i-1];
        kept[pos] = s;
        if (kept_n < CAPACITY) kept_n++;
    endfunction

    function automatic t_ranked ranked_pick();
        t_ranked r;
        int      k;
        k = rank_reg;
        if (k == 0) k = 1;
        if (k > CAPACITY) k = CAPACITY;
        r.full = (kept_n >= k);
        if (r.full) begin
            r.kth = kept[k-1];
        end else if (kept_n > 0) begin
            r.kth = kept[kept_n-1];
        end else begin
            r.kth = '0;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_ranked want;
        if (!i_rst_n) begin
            kept_n   = 0;
            rank_reg = 1;
            ranked_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (ranked_q.size() == 0) begin
                    report_mismatch("result transaction arrived with nothing outstanding");
                end else begin
                    want = ranked_q.pop_front();
                    checked_total++;
                    if (i_kth_value !== want.kth)
                        report_mismatch($sformatf("result %0d: kth_value %0d, predicted %0d",
                            checked_total, i_kth_value, want.kth));
                    if (i_full_res !== want.full)
                        report_mismatch($sformatf("result %0d: full_res %b, predicted %b",
                            checked_total, i_full_res, want.full));
                end
            end
            if (i_cfg_we) rank_reg = i_cfg_wdata;
            if (i_in_valid && !i_in_stall) begin
                keep_sample(i_sample);
                ranked_q.push_back(ranked_pick());
            end
        end
        outstanding <= ranked_q.size();
    end

endmodule

// ===== bench/stream_kth_largest_core_test.sv =====
// Top of the testbench for stream_kth_largest_core: clock, reset, samples, rank writes
// and back-pressure, with the verdict. Depends on skl_pkg, the block and the checker.
`timescale 1ns / 1ps

module stream_kth_largest_core_test;

    localparam int CAP         = skl_pkg::CAPACITY_DEF;
    localparam int SB          = skl_pkg::SAMPLE_BITS_DEF;
    localparam int RB          = skl_pkg::RANK_BITS;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 45;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic signed [SB-1:0]  i_sample = '0;
    logic                  i_stall = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [RB-1:0]         i_cfg_wdata = '0;
    logic                  o_stall;
    logic                  o_valid;
    logic signed [SB-1:0]  o_kth_value;
    logic                  o_full_res;

    int fail_count;
    int outstanding;
    int checked;
    int cycle_count = 0;
    int n_sent = 0;
    int n_rank_writes = 0;
    bit calm = 1'b0;

    logic signed [SB-1:0] ramp = '0;
    logic signed [SB-1:0] recent [$];

    stream_kth_largest_core #(.CAPACITY(CAP), .SAMPLE_BITS(SB)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_sample    (i_sample),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_kth_value (o_kth_value),
        .o_full_res  (o_full_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    stream_kth_largest_checker #(.CAPACITY(CAP), .SAMPLE_BITS(SB)) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_sample      (i_sample),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_kth_value   (o_kth_value),
        .i_full_res    (o_full_res),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                cycle_count, outstanding);
            $display("stream_kth_largest_core test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || calm) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < 15);
        end
    end

    task automatic send_sample(input logic signed [SB-1:0] s);
        i_sample <= s;
        while (!calm && $urandom_range(99) < 15) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        n_sent++;
        recent.push_back(s);
        if (recent.size() > 16) void'(recent.pop_front());
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_rank(input logic [RB-1:0] k);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= k;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        n_rank_writes++;
    endtask

    // A mix of full-range values, tight clusters for duplicates, extremes, a rising
    // ramp that keeps displacing the smallest held sample, and repeats of recent values.
    function automatic logic signed [SB-1:0] pick_sample();
        int sel;
        sel = $urandom_range(99);
        if (sel < 35) return SB'($urandom);
        if (sel < 55) return SB'($urandom_range(16) - 8);
        if (sel < 65) begin
            case ($urandom_range(3))
                0: return {1'b1, {(SB-1){1'b0}}};
                1: return {1'b0, {(SB-1){1'b1}}};
                2: return {1'b1, {(SB-2){1'b0}}, 1'b1};
                default: return {1'b0, {(SB-2){1'b1}}, 1'b0};
            endcase
        end
        if (sel < 85 || recent.size() == 0) begin
            ramp = SB'(ramp + $urandom_range(200));
            return ramp;
        end
        return recent[$urandom_range(recent.size() - 1)];
    endfunction

    initial begin
        int rank_plan [PHASES];
        int k;
        rank_plan = '{64, 1, 2, 127, 0, -1, 65, -1, 63, 1};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_sample(16'sh8000);
        send_sample(16'sh7fff);
        send_sample(16'sh0000);
        send_sample(16'shffff);
        send_sample(16'sh0001);
        set_rank(RB'(0));
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sh5555);
        send_sample(16'shaaaa);
        set_rank(RB'(127));
        send_sample(16'sh0000);
        send_sample(16'sh0000);
        send_sample(16'shffff);
        set_rank(RB'(3));
        send_sample(16'sh8001);
        send_sample(16'sh7ffe);

        for (int p = 0; p < PHASES; p++) begin
            k = (rank_plan[p] < 0) ? $urandom_range(127) : rank_plan[p];
            set_rank(RB'(k));
            calm = (p == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) send_sample(pick_sample());
        end
        calm = 1'b0;

        drain();
        repeat (6) @(posedge i_clk);

        $display("Sent %0d samples under %0d rank writes, ranks 0 to 127 among them.",
            n_sent, n_rank_writes);
        $display("Compared %0d results, with random gaps and back-pressure.", checked);
        if (fail_count == 0 && outstanding == 0) begin
            $display("stream_kth_largest_core test passed");
        end else begin
            $display("stream_kth_largest_core test failed");
        end
        $finish;
    end

endmodule
